FILE: hw/rtl/fpm_pkg.sv
`default_nettype none
package fpm_pkg;

    localparam logic [9:0] EXP_BIAS_ADD = 10'd129;
    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
    localparam logic [4:0] LEAD_POINT   = 5'd23;
    localparam logic [4:0] LEAD_BIAS    = 5'd24;

    typedef struct packed {
        logic        b_nan;
        logic        a_nan;
        logic        inf_zero;
        logic        inf;
        logic        zero;
        logic        den;
        logic        sa;
        logic        sb;
        logic        sc;
        logic [9:0]  e;
        logic [27:0] m;
        logic        found;
        logic [4:0]  lead;
    } t_s2;

endpackage
`default_nettype wire

FILE: hw/rtl/fpm_round.sv
`default_nettype none
module fpm_round (
    input  var fpm_pkg::t_s2 i_s2,
    output logic [31:0]      o_product
);

    logic [9:0]  e_adj;
    logic [31:0] f;
    logic [27:0] t;
    logic [4:0]  sh;
    logic        ovf;
    logic        unf;

    always_comb begin
        e_adj = i_s2.e;
        f     = {4'd0, i_s2.m};
        t     = i_s2.m;
        sh    = 5'd0;
        if (i_s2.den) begin
            if (i_s2.found) begin
                e_adj = i_s2.e + {5'd0, i_s2.lead} - {5'd0, fpm_pkg::LEAD_BIAS};
                if (i_s2.lead > fpm_pkg::LEAD_POINT) begin
                    sh = i_s2.lead - fpm_pkg::LEAD_POINT;
                    t  = i_s2.m + (i_s2.m & (28'd1 << (i_s2.lead - fpm_pkg::LEAD_BIAS)));
                    f  = {4'd0, t >> sh};
                end else if (i_s2.lead != fpm_pkg::LEAD_POINT) begin
                    sh = fpm_pkg::LEAD_POINT - i_s2.lead;
                    f  = ({4'd0, i_s2.m} << sh) + (32'd1 << (sh - 5'd1));
                end
            end
        end else if (i_s2.m[26]) begin
            e_adj = i_s2.e + 10'd1;
            t     = i_s2.m + {25'd0, i_s2.m[2], 2'b00};
            f     = {4'd0, t >> 3};
        end else begin
            t = i_s2.m + {26'd0, i_s2.m[1], 1'b0};
            f = {4'd0, t >> 2};
        end

        ovf = e_adj[9] || (e_adj[8] && e_adj[7:0] == fpm_pkg::EXP_ALL_ONES);
        unf = !e_adj[8] || e_adj[7:0] == 8'd0;

        if (i_s2.b_nan) begin
            o_product = {i_s2.sb, fpm_pkg::EXP_ALL_ONES, 23'd0};
        end else if (i_s2.a_nan) begin
            o_product = {i_s2.sa, fpm_pkg::EXP_ALL_ONES, 23'd0};
        end else if (i_s2.inf_zero) begin
            o_product = {1'b1, fpm_pkg::EXP_ALL_ONES, 23'd0};
        end else if (i_s2.inf) begin
            o_product = {i_s2.sc, fpm_pkg::EXP_ALL_ONES, 23'd0};
        end else if (i_s2.zero) begin
            o_product = {i_s2.sc, 31'd0};
        end else if (ovf) begin
            o_product = {i_s2.sc, fpm_pkg::EXP_ALL_ONES, 23'd0};
        end else if (unf) begin
            o_product = {i_s2.sc, 31'd0};
        end else begin
            o_product = {i_s2.sc, e_adj[7:0], f[22:0]};
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fp32_multiplier.sv
`default_nettype none
// Binary32 multiplier with a truncated significand, three register stages (partial
// products, significand sum with leading-one search, normalise and round into the
// output register). A word may enter every cycle and its product passes through all three
// registers; the whole pipeline holds while a finished product is stalled. Denormal results
// flush to zero, overflow saturates to infinity and NaN operands give an infinity pattern.
module fp32_multiplier (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_a_operand,
    input  wire logic [31:0] i_b_operand,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_product
);

    logic        adv;
    logic        r1_v, r2_v, r3_v;
    logic [25:0] r1_hh, n1_hh;
    logic [23:0] r1_hl, n1_hl, r1_lh, n1_lh;
    logic [9:0]  r1_e, n1_e;
    logic [8:0]  r1_fl, n1_fl;
    fpm_pkg::t_s2 r2_s, n2_s;
    logic [31:0] r3_p, n3_p;

    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, a_inf, a_zero, a_den, b_nan, b_inf, b_zero, b_den;
    logic [12:0] ahi, bhi;
    logic [27:0] m;
    logic [4:0]  lead;

    assign adv     = !(r3_v && i_stall);
    assign o_stall = !adv;
    assign o_valid = r3_v;
    assign o_product = r3_p;

    always_comb begin
        ea     = i_a_operand[30:23];
        eb     = i_b_operand[30:23];
        fa     = i_a_operand[22:0];
        fb     = i_b_operand[22:0];
        a_nan  = ea == fpm_pkg::EXP_ALL_ONES && fa != 23'd0;
        a_inf  = ea == fpm_pkg::EXP_ALL_ONES && fa == 23'd0;
        a_zero = ea == 8'd0 && fa == 23'd0;
        a_den  = ea == 8'd0 && fa != 23'd0;
        b_nan  = eb == fpm_pkg::EXP_ALL_ONES && fb != 23'd0;
        b_inf  = eb == fpm_pkg::EXP_ALL_ONES && fb == 23'd0;
        b_zero = eb == 8'd0 && fb == 23'd0;
        b_den  = eb == 8'd0 && fb != 23'd0;
        ahi    = {!a_den, fa[22:11]};
        bhi    = {!b_den, fb[22:11]};
        n1_hh  = {13'd0, ahi} * {13'd0, bhi};
        n1_hl  = {11'd0, ahi} * {13'd0, fb[10:0]};
        n1_lh  = {13'd0, fa[10:0]} * {11'd0, bhi};
        n1_e   = {2'd0, ea} + {2'd0, eb} + fpm_pkg::EXP_BIAS_ADD;
        n1_fl  = {b_nan, a_nan, (a_inf || b_inf) && (a_zero || b_zero), a_inf || b_inf,
                  a_zero || b_zero, a_den || b_den, i_a_operand[31], i_b_operand[31],
                  i_a_operand[31] ^ i_b_operand[31]};
    end

    always_comb begin
        m    = {1'b0, r1_hh, 1'b0} + 28'd1 + {14'd0, r1_hl[23:10]} + {14'd0, r1_lh[23:10]};
        lead = 5'd0;
        for (int k = 1; k <= 26; k++) begin
            if (m[k]) begin
                lead = 5'(k);
            end
        end
        n2_s = '{b_nan: r1_fl[8], a_nan: r1_fl[7], inf_zero: r1_fl[6], inf: r1_fl[5],
                 zero: r1_fl[4], den: r1_fl[3], sa: r1_fl[2], sb: r1_fl[1], sc: r1_fl[0],
                 e: r1_e, m: m, found: |m[26:1], lead: lead};
    end

    fpm_round u_round (
        .i_s2      (r2_s),
        .o_product (n3_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_hh <= n1_hh;
            r1_hl <= n1_hl;
            r1_lh <= n1_lh;
            r1_e  <= n1_e;
            r1_fl <= n1_fl;
            r2_s  <= n2_s;
            r3_p  <= n3_p;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fp32_multiplier_checker.sv
`default_nettype none
module fp32_multiplier_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_product
);

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall) else $error("input stalled with no word waiting");

    a_word_arrives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted word did not reach the output");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("output word dropped while stalled");

    a_product_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_product)) else $error("stalled product changed");

endmodule

bind fp32_multiplier fp32_multiplier_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_product (o_product)
);
`default_nettype wire

FILE: bench/tb_fp32_multiplier.sv
`default_nettype none
module tb_fp32_multiplier;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_pair;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] a_op = '0;
    logic [31:0] b_op = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] product;

    t_pair       pending_pairs[$];
    logic [31:0] expected_products[$];
    int          errors = 0;
    int          idle_cnt = 0;
    int          gap = 0;
    int          hold = 0;
    int          stall_left = 0;
    bit          hold_done = 1'b0;
    bit          stim_done = 1'b0;

    fp32_multiplier u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_a_operand(a_op),
        .i_b_operand(b_op),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_product  (product)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        sa, sb, sc;
        logic [7:0]  ea, eb;
        logic [22:0] fa, fb;
        logic        an, ai, az, ad, bn, bi, bz, bd;
        logic [31:0] e, m, ahi, bhi, alo, blo;
        int          i;
        sa = a[31]; sb = b[31]; sc = sa ^ sb;
        ea = a[30:23]; eb = b[30:23];
        fa = a[22:0]; fb = b[22:0];
        an = (ea == 8'hFF) && (fa != 0); ai = (ea == 8'hFF) && (fa == 0);
        az = (ea == 0) && (fa == 0);     ad = (ea == 0) && (fa != 0);
        bn = (eb == 8'hFF) && (fb != 0); bi = (eb == 8'hFF) && (fb == 0);
        bz = (eb == 0) && (fb == 0);     bd = (eb == 0) && (fb != 0);
        e = 32'(ea) + 32'(eb) + 32'd129;
        ahi = 32'(fa[22:11]) | (ad ? 32'd0 : 32'h1000);
        bhi = 32'(fb[22:11]) | (bd ? 32'd0 : 32'h1000);
        alo = 32'(fa[10:0]); blo = 32'(fb[10:0]);
        m = ((ahi * bhi) << 1) + 32'd1 + ((ahi * blo) >> 10) + ((alo * bhi) >> 10);
        if (ad || bd) begin
            for (i = 26; i > 0; i--) begin
                if ((m >> i) != 0) begin
                    e = e + 32'(i) - 32'd24;
                    if (i > 23) begin
                        m = m + (m & (32'd1 << (i - 24)));
                        m = m >> (i - 23);
                    end else if (i != 23) begin
                        m = m << (23 - i);
                        m = m + (32'd1 << (22 - i));
                    end
                    break;
                end
            end
        end else if (m[26]) begin
            e = e + 32'd1;
            m = m + (32'(m[2]) << 2);
            m = m >> 3;
        end else begin
            m = m + (32'(m[1]) << 1);
            m = m >> 2;
        end
        if (bn) return {sb, 8'hFF, 23'd0};
        if (an) return {sa, 8'hFF, 23'd0};
        if ((ai || bi) && (az || bz)) return 32'hFF80_0000;
        if (ai || bi) return {sc, 8'hFF, 23'd0};
        if (az || bz) return {sc, 31'd0};
        if (e[9] || (e[8] && e[7:0] == 8'hFF)) return {sc, 8'hFF, 23'd0};
        if (!e[8] || e[7:0] == 0) return {sc, 31'd0};
        return {sc, e[7:0], m[22:0]};
    endfunction

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hFF;
            2: v[22:0] = '0;
            3: v[30:23] = 8'(127 + $urandom_range(0, 4) - 2);
            4: begin
                v[30:23] = 8'h00;
                v[22:0] = 23'h7FFFFF >> $urandom_range(0, 22);
            end
            default: v[30:23] = 8'($urandom_range(60, 190));
        endcase
        return v;
    endfunction

    initial begin
        logic [31:0] edge_vals[12];
        t_pair p;
        edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                      32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                      32'h3F80_0000, 32'h7F7F_FFFF, 32'h0080_0000, 32'h3FFF_FFFF};
        foreach (edge_vals[k]) begin
            p.a = edge_vals[k];
            p.b = edge_vals[(k * 5 + 3) % 12];
            pending_pairs.push_back(p);
            p.b = edge_vals[k];
            pending_pairs.push_back(p);
        end
        repeat (500) begin
            p.a = rand_operand();
            p.b = rand_operand();
            pending_pairs.push_back(p);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_products.push_back(fp_mul(a_op, b_op));
                gap = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0) gap = 0;
            end
            if (!in_valid || !in_stall) begin
                if (gap > 0 || pending_pairs.size() == 0) begin
                    if (gap > 0) gap--;
                    in_valid <= 1'b0;
                    if (pending_pairs.size() == 0 && !(in_valid && in_stall))
                        stim_done <= 1'b1;
                end else begin
                    t_pair p;
                    p = pending_pairs.pop_front();
                    a_op <= p.a;
                    b_op <= p.b;
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_products.size() == 0) begin
                    $error("product: unexpected word, actual %h", product);
                    errors++;
                end else begin
                    logic [31:0] exp_p;
                    exp_p = expected_products.pop_front();
                    if (product !== exp_p) begin
                        $error("product: expected %h actual %h", exp_p, product);
                        errors++;
                    end
                end
            end
            if (!hold_done && pending_pairs.size() < 300) begin
                hold_done <= 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if (out_valid && $urandom_range(0, 1) == 0)
                    stall_left = $urandom_range(0, 3);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_products.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_products.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
